[src/rv32im_execute_core_unit_defines.svh]
// Assertion macros for the execute core.
`ifndef RV32IM_EXECUTE_CORE_UNIT_DEFINES_SVH
`define RV32IM_EXECUTE_CORE_UNIT_DEFINES_SVH
// Property checked every clock edge outside reset.
`define RV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Implication to the next cycle.
`define RV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`endif

[src/rv32ex_pkg.sv]
// Shared constants for the RV32IM execute core.
package rv32ex_pkg;
  localparam int NUM_REGS_DEF = 32;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_SYSTEM = 7'h73;
  localparam logic [31:0] UPPER_MASK = 32'hFFFFF000;
  localparam logic [25:0] STEP_LIMIT_RST = 26'd50000000;

  localparam logic [1:0] FN_INSTR = 2'd0;
  localparam logic [1:0] FN_RESP  = 2'd1;
  localparam logic [1:0] FN_PRE   = 2'd2;

  localparam logic [2:0] K_FETCH = 3'd0;
  localparam logic [2:0] K_LOAD  = 3'd1;
  localparam logic [2:0] K_STORE = 3'd2;
  localparam logic [2:0] K_STOP  = 3'd3;
  localparam logic [2:0] K_PRE   = 3'd4;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [2:0] PA_NONE  = 3'd0;
  localparam logic [2:0] PA_LB    = 3'd1;
  localparam logic [2:0] PA_LH    = 3'd2;
  localparam logic [2:0] PA_LW    = 3'd3;
  localparam logic [2:0] PA_LBU   = 3'd4;
  localparam logic [2:0] PA_LHU   = 3'd5;
  localparam logic [2:0] PA_STORE = 3'd6;

  localparam logic [2:0] MD_MUL    = 3'd0;
  localparam logic [2:0] MD_MULH   = 3'd1;
  localparam logic [2:0] MD_MULHSU = 3'd2;
  localparam logic [2:0] MD_MULHU  = 3'd3;

  typedef struct packed {
    logic        go;
    logic [2:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } md_req_t;
endpackage

[src/rv32ex_muldiv.sv]
// Iterative multiply / divide unit, one bit per cycle.
module rv32ex_muldiv
  import rv32ex_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  md_req_t     req,
  output logic        done,
  output logic [31:0] result
);
  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_RUN  = 2'd1;
  localparam logic [1:0] M_FIN  = 2'd2;

  logic [1:0]  phase;
  logic [4:0]  cnt;
  logic [31:0] hi, lo, mc, a_q;
  logic [2:0]  op_q;
  logic        negp, bz;

  logic        is_mul, sgn_a, sgn_b, na, nb;
  logic [31:0] ma, mb;
  logic [32:0] msum, dsub;
  logic [63:0] prod, prod_s;
  logic [31:0] dv, dv_s;

  always_comb begin
    is_mul = !req.op[2];
    sgn_a  = is_mul ? (req.op != MD_MULHU) : !req.op[0];
    sgn_b  = is_mul ? (req.op == MD_MUL || req.op == MD_MULH) : !req.op[0];
    na     = sgn_a & req.a[31];
    nb     = sgn_b & req.b[31];
    ma     = na ? (32'd0 - req.a) : req.a;
    mb     = nb ? (32'd0 - req.b) : req.b;
    msum   = {1'b0, hi} + (lo[0] ? {1'b0, mc} : 33'd0);
    dsub   = {hi, lo[31]} - {1'b0, mc};
    prod   = {hi, lo};
    prod_s = negp ? (64'd0 - prod) : prod;
    dv     = op_q[1] ? hi : lo;
    dv_s   = negp ? (32'd0 - dv) : dv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        M_IDLE: begin
          if (req.go) begin
            phase <= M_RUN;
            cnt   <= '0;
            op_q  <= req.op;
            a_q   <= req.a;
            bz    <= (req.b == 32'd0);
            negp  <= is_mul ? (na ^ nb) : (req.op[1] ? na : (na ^ nb));
            hi    <= '0;
            lo    <= is_mul ? mb : ma;
            mc    <= is_mul ? ma : mb;
          end
        end
        M_RUN: begin
          if (!op_q[2]) begin
            hi <= msum[32:1];
            lo <= {msum[0], lo[31:1]};
          end else if (!dsub[32]) begin
            hi <= dsub[31:0];
            lo <= {lo[30:0], 1'b1};
          end else begin
            hi <= {hi[30:0], lo[31]};
            lo <= {lo[30:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) phase <= M_FIN;
        end
        M_FIN: begin
          if (!op_q[2]) result <= (op_q == MD_MUL) ? prod_s[31:0] : prod_s[63:32];
          else if (bz) result <= op_q[1] ? a_q : 32'hFFFFFFFF;
          else result <= dv_s;
          done  <= 1'b1;
          phase <= M_IDLE;
        end
        default: phase <= M_IDLE;
      endcase
    end
  end
endmodule

[src/rv32im_execute_core_unit.sv]
// RV32IM execute core: one request or stop report per input beat.
// Path to m_axis_tvalid: preload, response and check-stage stop beats go from the check
// state to emit; other instructions pass two register file reads, execute and emit;
// multiply, divide and remainder also wait on the bit-serial unit before emit.
// Input: next beat taken the cycle after the result registers, and no new beat before;
// reset: synchronous; pc, register valid bits, step count and pending access cleared.
`include "rv32im_execute_core_unit_defines.svh"
module rv32im_execute_core_unit
  import rv32ex_pkg::*;
#(
  parameter int NUM_REGS = NUM_REGS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // instr_word, mem_data, mem_fault, reg_index, reg_value, zero pad
  input  logic [103:0] s_axis_tdata,
  // func
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // mem_addr, mem_size, store_data, status, stop_pc, initial_return, zero pad
  output logic [135:0] m_axis_tdata,
  // kind
  output logic [2:0]   m_axis_tuser,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [31:0]  cfg_wdata
);
  localparam int RW = $clog2(NUM_REGS);
  localparam logic [5:0] NREG = 6'(NUM_REGS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_MD   = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]  state, state_next;
  logic [31:0] ret_addr;
  logic [25:0] step_limit;
  logic [31:0] pc, pc_next;
  logic [25:0] steps, steps_next;
  logic [2:0]  pend, pend_next;
  logic [4:0]  pdest, pdest_next;
  logic [1:0]  run, run_next;
  logic [31:0] x1;

  logic [1:0]  func;
  logic [31:0] iw, mdata, rval;
  logic        fault;
  logic [4:0]  ridx;

  logic [2:0]  rk, rk_next;
  logic [31:0] raddr, raddr_next, rdat, rdat_next;
  logic [1:0]  rsize, rsize_next;

  logic [31:0] opa, opa_next;

  logic [31:0] rf [NUM_REGS];
  logic [NUM_REGS-1:0] vld;
  logic [31:0] rf_q;
  logic        rf_ok;
  logic [4:0]  rd_sel;
  logic [31:0] rdval;

  logic        wr_en;
  logic [4:0]  wr_idx;
  logic [31:0] wr_val;

  md_req_t     md_req;
  logic        md_done;
  logic [31:0] md_res;

  logic        ovalid;
  logic [2:0]  o_kind;
  logic [31:0] o_addr, o_data, o_fpc, o_x1;
  logic [1:0]  o_size, o_st;

  logic        do_stop, do_adv;
  logic [1:0]  stop_st;
  logic [31:0] npc;
  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] b, immi, imms, immb, immj, v, ld;
  logic [4:0]  sh;
  logic        take, emit_ok;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = ovalid;
  assign m_axis_tuser  = o_kind;
  assign m_axis_tdata  = {4'd0, o_x1, o_fpc, o_st, o_data, o_size, o_addr};
  assign rdval  = rf_ok ? rf_q : 32'd0;
  assign rd_sel = (state == S_CHK) ? iw[19:15] : iw[24:20];
  assign emit_ok = !ovalid || m_axis_tready;

  rv32ex_muldiv u_md (
    .clk    (clk),
    .rst    (rst),
    .req    (md_req),
    .done   (md_done),
    .result (md_res)
  );

  always_comb begin
    state_next = state;
    pc_next = pc; steps_next = steps; pend_next = pend; pdest_next = pdest;
    run_next = run;
    rk_next = rk; raddr_next = raddr; rdat_next = rdat; rsize_next = rsize;
    opa_next = opa;
    wr_en = 1'b0; wr_idx = iw[11:7]; wr_val = 32'd0;
    md_req.go = 1'b0;
    md_req.op = iw[14:12];
    md_req.a  = opa;
    md_req.b  = rdval;
    do_stop = 1'b0; stop_st = ST_ERR; do_adv = 1'b0; npc = pc + 32'd4;
    op = iw[6:0]; rd = iw[11:7]; f3 = iw[14:12]; f7 = iw[31:25];
    b = rdval; sh = iw[24:20];
    immi = {{20{iw[31]}}, iw[31:20]};
    imms = {{20{iw[31]}}, iw[31:25], iw[11:7]};
    immb = {{20{iw[31]}}, iw[7], iw[30:25], iw[11:8], 1'b0};
    immj = {{12{iw[31]}}, iw[19:12], iw[20], iw[30:21], 1'b0};
    v = 32'd0; take = 1'b0;
    case (pend)
      PA_LB:   ld = {{24{mdata[7]}}, mdata[7:0]};
      PA_LH:   ld = {{16{mdata[15]}}, mdata[15:0]};
      PA_LBU:  ld = {24'd0, mdata[7:0]};
      PA_LHU:  ld = {16'd0, mdata[15:0]};
      PA_LW:   ld = mdata;
      default: ld = 32'd0;
    endcase

    case (state)
      S_IDLE: if (s_axis_tvalid) state_next = S_CHK;
      S_CHK: begin
        if (func == FN_PRE) begin
          if (ridx == 5'd0) begin
            pc_next = rval; steps_next = '0; pend_next = PA_NONE; run_next = ST_RUN;
          end else begin
            wr_en = 1'b1; wr_idx = ridx; wr_val = rval;
          end
          rk_next = K_PRE; raddr_next = (ridx == 5'd0) ? rval : pc;
          rsize_next = 2'd2; rdat_next = 32'd0;
          state_next = S_EMIT;
        end else if (run != ST_RUN) begin
          rk_next = K_STOP; raddr_next = 32'd0; rsize_next = 2'd0; rdat_next = 32'd0;
          state_next = S_EMIT;
        end else if (func == FN_INSTR) begin
          if (pend != PA_NONE || steps >= step_limit) begin
            do_stop = 1'b1;
          end else begin
            steps_next = steps + 26'd1;
            if (fault) do_stop = 1'b1;
            else state_next = S_RD2;
          end
        end else if (func == FN_RESP && pend != PA_NONE) begin
          if (fault) begin
            do_stop = 1'b1;
          end else begin
            wr_en = (pend != PA_STORE); wr_idx = pdest; wr_val = ld;
            pend_next = PA_NONE;
            do_adv = 1'b1;
          end
        end else begin
          do_stop = 1'b1;
        end
      end
      S_RD2: begin
        opa_next = rdval;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        case (op)
          OP_LUI: begin
            wr_en = 1'b1; wr_val = iw & UPPER_MASK; do_adv = 1'b1;
          end
          OP_AUIPC: begin
            wr_en = 1'b1; wr_val = pc + (iw & UPPER_MASK); do_adv = 1'b1;
          end
          OP_JAL: begin
            wr_en = 1'b1; wr_val = pc + 32'd4; do_adv = 1'b1; npc = pc + immj;
          end
          OP_JALR: begin
            if (f3 != 3'd0) do_stop = 1'b1;
            else begin
              wr_en = 1'b1; wr_val = pc + 32'd4; do_adv = 1'b1;
              npc = (opa + immi) & 32'hFFFFFFFE;
            end
          end
          OP_BRANCH: begin
            case (f3)
              3'd0: take = (opa == b);
              3'd1: take = (opa != b);
              3'd4: take = ($signed(opa) < $signed(b));
              3'd5: take = !($signed(opa) < $signed(b));
              3'd6: take = (opa < b);
              3'd7: take = (opa >= b);
              default: do_stop = 1'b1;
            endcase
            do_adv = !do_stop;
            if (take) npc = pc + immb;
          end
          OP_LOAD: begin
            case (f3)
              3'd0: pend_next = PA_LB;
              3'd1: pend_next = PA_LH;
              3'd2: pend_next = PA_LW;
              3'd4: pend_next = PA_LBU;
              3'd5: pend_next = PA_LHU;
              default: do_stop = 1'b1;
            endcase
            if (!do_stop) begin
              pdest_next = rd; rk_next = K_LOAD; raddr_next = opa + immi;
              rsize_next = f3[1:0]; rdat_next = 32'd0; state_next = S_EMIT;
            end
          end
          OP_STORE: begin
            if (f3 > 3'd2) do_stop = 1'b1;
            else begin
              pend_next = PA_STORE; rk_next = K_STORE; raddr_next = opa + imms;
              rsize_next = f3[1:0]; rdat_next = b; state_next = S_EMIT;
            end
          end
          OP_IMM: begin
            case (f3)
              3'd0: v = opa + immi;
              3'd2: v = {31'd0, $signed(opa) < $signed(immi)};
              3'd3: v = {31'd0, opa < immi};
              3'd4: v = opa ^ immi;
              3'd6: v = opa | immi;
              3'd7: v = opa & immi;
              3'd1: begin
                if (f7 != 7'd0) do_stop = 1'b1;
                v = opa << sh;
              end
              default: begin
                if (f7 == 7'd0) v = opa >> sh;
                else if (f7 == 7'h20) v = 32'($signed(opa) >>> sh);
                else do_stop = 1'b1;
              end
            endcase
            wr_en = !do_stop; wr_val = v; do_adv = !do_stop;
          end
          OP_REG: begin
            if (f7 == 7'd1) begin
              md_req.go = 1'b1;
              state_next = S_MD;
            end else begin
              if (f7 == 7'd0) begin
                case (f3)
                  3'd0: v = opa + b;
                  3'd1: v = opa << b[4:0];
                  3'd2: v = {31'd0, $signed(opa) < $signed(b)};
                  3'd3: v = {31'd0, opa < b};
                  3'd4: v = opa ^ b;
                  3'd5: v = opa >> b[4:0];
                  3'd6: v = opa | b;
                  default: v = opa & b;
                endcase
              end else if (f7 == 7'h20 && f3 == 3'd0) v = opa - b;
              else if (f7 == 7'h20 && f3 == 3'd5) v = 32'($signed(opa) >>> b[4:0]);
              else do_stop = 1'b1;
              wr_en = !do_stop; wr_val = v; do_adv = !do_stop;
            end
          end
          OP_SYSTEM: begin
            do_stop = 1'b1;
            if (f3 == 3'd0 && iw[31:21] == 11'd0) stop_st = ST_HALT;
          end
          default: do_stop = 1'b1;
        endcase
      end
      S_MD: begin
        if (md_done) begin
          wr_en = 1'b1; wr_val = md_res; do_adv = 1'b1;
        end
      end
      S_EMIT: if (emit_ok) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase

    if (do_adv) begin
      pc_next = npc;
      if (npc == ret_addr) begin
        do_stop = 1'b1; stop_st = ST_HALT;
      end else begin
        rk_next = K_FETCH; raddr_next = npc; rsize_next = 2'd2; rdat_next = 32'd0;
        state_next = S_EMIT;
      end
    end
    if (do_stop) begin
      run_next = stop_st; pend_next = PA_NONE;
      rk_next = K_STOP; raddr_next = 32'd0; rsize_next = 2'd0; rdat_next = 32'd0;
      state_next = S_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    rf_q  <= rf[rd_sel[RW-1:0]];
    rf_ok <= ({1'b0, rd_sel} < NREG) && vld[rd_sel[RW-1:0]];
    if (wr_en && wr_idx != 5'd0 && {1'b0, wr_idx} < NREG) rf[wr_idx[RW-1:0]] <= wr_val;
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      iw    <= s_axis_tdata[31:0];
      mdata <= s_axis_tdata[63:32];
      fault <= s_axis_tdata[64];
      ridx  <= s_axis_tdata[69:65];
      rval  <= s_axis_tdata[101:70];
      func  <= s_axis_tuser;
    end
    rk <= rk_next; raddr <= raddr_next; rdat <= rdat_next; rsize <= rsize_next;
    opa <= opa_next; pdest <= pdest_next;
    if (state == S_EMIT && emit_ok) begin
      o_kind <= rk; o_addr <= raddr; o_size <= rsize; o_data <= rdat;
      o_st <= run; o_fpc <= pc; o_x1 <= x1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret_addr <= '0;
      step_limit <= STEP_LIMIT_RST;
      pc <= '0;
      steps <= '0;
      pend <= PA_NONE;
      run <= ST_RUN;
      vld <= '0;
      x1 <= '0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      pc <= pc_next;
      steps <= steps_next;
      pend <= pend_next;
      run <= run_next;
      if (cfg_we) begin
        if (cfg_addr) step_limit <= cfg_wdata[25:0];
        else ret_addr <= cfg_wdata;
      end
      if (wr_en && wr_idx != 5'd0 && {1'b0, wr_idx} < NREG) begin
        vld[wr_idx[RW-1:0]] <= 1'b1;
        if (wr_idx == 5'd1) x1 <= wr_val;
      end
      if (state == S_EMIT && emit_ok) ovalid <= 1'b1;
      else if (m_axis_tready) ovalid <= 1'b0;
    end
  end

  `RV_ASSERT(a_stop_no_pend, (run != ST_RUN) |-> (pend == PA_NONE), "pending access while stopped")
  `RV_ASSERT(a_md_done_state, md_done |-> (state == S_MD), "divider result outside wait state")
  `RV_ASSERT_NEXT(a_accept_chk, (s_axis_tvalid && s_axis_tready), (state == S_CHK), "beat not checked")
endmodule
